>>> rtl/core/pmbc_pkg.sv
// Shared types and constants for the position-modulo byte checksum.
// Defines the token that travels along the divider chain and the register indexes.
// No dependencies.
package pmbc_pkg;

    localparam int LENGTH_BITS   = 24;
    localparam int BYTE_BITS     = 8;
    localparam int DVD_BITS      = LENGTH_BITS + 1;   // byte + bytes still to follow
    localparam int REM_BITS      = BYTE_BITS + 1;     // divisor reaches 256
    localparam int SUM_BITS      = 32;
    localparam int OFFSET_BITS   = 8;
    localparam int CELLS         = DVD_BITS;          // one quotient bit per cell
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = LENGTH_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHECKSUM_OFFSET = 2'd1;

    // One byte on its way through the divider chain
    typedef struct packed {
        logic                valid;
        logic                last;   // final byte of the file
        logic                field;  // byte belongs to the stored checksum field
        logic [1:0]          fidx;   // byte lane within the stored field
        logic [DVD_BITS-1:0] dvd;    // dividend bits not yet consumed, MSB first
        logic [REM_BITS-1:0] rem;    // partial remainder
        logic [REM_BITS-1:0] div;    // divisor, byte + 1
    } token_t;

endpackage

>>> rtl/core/position_modulo_byte_checksum.sv
// Top level of the position-modulo byte checksum: front end, divider chain, tail.
// Depends on pmbc_pkg, pmbc_front, pmbc_cell, pmbc_tail.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  byte_value
//   out      source     out_valid / out_stall checksum_value, checksum_match
//   cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is taken every cycle while in_stall is low; each byte runs through a
// chain of 25 division cells, one dividend bit per cell, and the tail registers
// the result of each file. Reset restarts the counters and empties the chain.
// in_stall rises only while a result waits on a stalled output and the next
// result has reached the end of the chain; then the whole chain holds.
// Configuration writes are always taken (cfg_ready is high).
module position_modulo_byte_checksum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pmbc_pkg::BYTE_BITS-1:0]      byte_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pmbc_pkg::SUM_BITS-1:0]       checksum_value,
    output logic                                checksum_match,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmbc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [pmbc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import pmbc_pkg::*;

    token_t chain [0:CELLS];
    token_t front_tok;
    token_t entry_tok;
    logic   adv;
    logic   accept;
    logic   restart;

    assign cfg_ready = 1'b1;
    assign in_stall  = !adv;
    assign accept    = in_valid && adv;

    pmbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .byte_value (byte_value),
        .tok        (front_tok),
        .restart    (restart)
    );

    // Feed the chain; an empty slot enters when no byte is offered
    always_comb
    begin
        entry_tok       = front_tok;
        entry_tok.valid = in_valid;
    end

    assign chain[0] = entry_tok;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        pmbc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    pmbc_tail u_tail (
        .clk            (clk),
        .rst_n          (rst_n),
        .restart        (restart),
        .tok            (chain[CELLS]),
        .out_stall      (out_stall),
        .adv            (adv),
        .out_valid      (out_valid),
        .checksum_value (checksum_value),
        .checksum_match (checksum_match)
    );

endmodule

>>> rtl/core/pmbc_front.sv
// Front end: configuration registers, byte position and bytes-remaining counters.
// Builds the dividend/divisor token for each accepted byte. Depends on pmbc_pkg.
module pmbc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [pmbc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pmbc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  accept,
    input  logic [pmbc_pkg::BYTE_BITS-1:0]        byte_value,
    output pmbc_pkg::token_t                      tok,
    output logic                                  restart
);
    import pmbc_pkg::*;

    logic [LENGTH_BITS-1:0] total_length_reg, total_length_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] len_eff;
    logic [LENGTH_BITS-1:0] r;
    logic [LENGTH_BITS-1:0] rel;
    logic [LENGTH_BITS-1:0] off_ext;
    logic                   last;

    // Zero length counts as one byte
    assign len_eff = (total_length_reg == '0) ? {{(LENGTH_BITS-1){1'b0}}, 1'b1}
                                              : total_length_reg;
    assign r       = remaining_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    assign last    = (r == '0);
    assign off_ext = {{(LENGTH_BITS-OFFSET_BITS){1'b0}}, offset_reg};
    assign rel     = pos_reg - off_ext;
    assign restart = cfg_valid && (cfg_index == REG_TOTAL_LENGTH);

    // Build the token for the byte on the input
    always_comb
    begin
        tok       = '0;
        tok.valid = 1'b1;
        tok.last  = last;
        tok.field = (pos_reg >= off_ext) && (rel < LENGTH_BITS'(4));
        tok.fidx  = rel[1:0];
        tok.dvd   = {1'b0, r} + {{(DVD_BITS-BYTE_BITS){1'b0}}, byte_value};
        tok.rem   = '0;
        tok.div   = {1'b0, byte_value} + {{(REM_BITS-1){1'b0}}, 1'b1};
    end

    // Counter and register updates
    always_comb
    begin
        total_length_next = total_length_reg;
        offset_next       = offset_reg;
        remaining_next    = remaining_reg;
        pos_next          = pos_reg;
        if (accept)
        begin
            if (last)
            begin
                remaining_next = len_eff;
                pos_next       = '0;
            end
            else
            begin
                remaining_next = r;
                pos_next       = pos_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            end
        end
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TOTAL_LENGTH:
                begin
                    total_length_next = cfg_data;
                    remaining_next    = (cfg_data == '0)
                                        ? {{(LENGTH_BITS-1){1'b0}}, 1'b1} : cfg_data;
                    pos_next          = '0;
                end
                REG_CHECKSUM_OFFSET:
                begin
                    offset_next = cfg_data[OFFSET_BITS-1:0];
                end
                default:
                begin
                    total_length_next = total_length_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg <= {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            offset_reg       <= '0;
            remaining_reg    <= {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            pos_reg          <= '0;
        end
        else
        begin
            total_length_reg <= total_length_next;
            offset_reg       <= offset_next;
            remaining_reg    <= remaining_next;
            pos_reg          <= pos_next;
        end
    end

    a_remaining_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg != '0)
        else $error("bytes remaining reached zero");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> (pos_reg == '0) && (remaining_reg == len_eff))
        else $error("file did not restart after its final byte");

endmodule

>>> rtl/core/pmbc_cell.sv
// One restoring-division cell: consumes one dividend bit per pass.
// Registers the token and hands it to the next cell. Depends on pmbc_pkg.
module pmbc_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  pmbc_pkg::token_t  tok_in,
    output pmbc_pkg::token_t  tok_out
);
    import pmbc_pkg::*;

    token_t              tok_reg, tok_next;
    logic [REM_BITS:0]   rem_sh;
    logic [REM_BITS:0]   rem_sub;
    logic                fits;

    // Shift in the next dividend bit, subtract when the divisor fits
    assign rem_sh  = {tok_in.rem, tok_in.dvd[DVD_BITS-1]};
    assign fits    = rem_sh >= {1'b0, tok_in.div};
    assign rem_sub = rem_sh - {1'b0, tok_in.div};

    always_comb
    begin
        tok_next     = tok_in;
        tok_next.dvd = {tok_in.dvd[DVD_BITS-2:0], 1'b0};
        tok_next.rem = fits ? rem_sub[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
    end

    // Advance with the whole chain; reset empties the cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg.valid |-> (tok_reg.rem < tok_reg.div))
        else $error("partial remainder not below divisor");

endmodule

>>> rtl/core/pmbc_tail.sv
// Tail of the chain: accumulates remainders, captures the stored field,
// and holds the finished result in the output register. Depends on pmbc_pkg.
module pmbc_tail (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              restart,
    input  pmbc_pkg::token_t                  tok,
    input  logic                              out_stall,
    output logic                              adv,
    output logic                              out_valid,
    output logic [pmbc_pkg::SUM_BITS-1:0]     checksum_value,
    output logic                              checksum_match
);
    import pmbc_pkg::*;

    logic [SUM_BITS-1:0]  sum_reg, sum_next;
    logic [SUM_BITS-1:0]  stored_reg, stored_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SUM_BITS-1:0]  value_reg;
    logic                 match_reg;
    logic [BYTE_BITS-1:0] b;
    logic                 take;
    logic                 finish;

    // Freeze the chain only when a second result would overrun a stalled one
    assign adv    = !(out_valid_reg && out_stall && tok.valid && tok.last);
    assign take   = adv && tok.valid;
    assign finish = take && tok.last;
    assign b      = tok.div[BYTE_BITS-1:0] - {{(BYTE_BITS-1){1'b0}}, 1'b1};

    always_comb
    begin
        stored_next = stored_reg;
        sum_next    = sum_reg;
        if (tok.field)
        begin
            stored_next = stored_reg
                          | ({{(SUM_BITS-BYTE_BITS){1'b0}}, b} << {tok.fidx, 3'b000});
        end
        else
        begin
            sum_next = sum_reg + {{(SUM_BITS-REM_BITS){1'b0}}, tok.rem};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            stored_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (restart || finish)
            begin
                sum_reg    <= '0;
                stored_reg <= '0;
            end
            else if (take)
            begin
                sum_reg    <= sum_next;
                stored_reg <= stored_next;
            end
        end
    end

    // Load the result on the final byte of a file
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            value_reg <= sum_next;
            match_reg <= (sum_next == stored_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign checksum_value = value_reg;
    assign checksum_match = match_reg;

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg)
        else $error("finished file produced no result");

    a_clear_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (sum_reg == '0) && (stored_reg == '0))
        else $error("accumulators not cleared after final byte");

endmodule
